// ===== rtl/core/upd_pkg.sv =====
package upd_pkg;

  // Deframer phases, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_HEADER   = 9'b000000010,
    PH_FIRMWARE = 9'b000000100,
    PH_NAMELEN  = 9'b000001000,
    PH_NAME     = 9'b000010000,
    PH_FILESIZE = 9'b000100000,
    PH_FILEDATA = 9'b001000000,
    PH_DONE     = 9'b010000000,
    PH_FAILED   = 9'b100000000
  } phase_e;

  // Event kinds carried by each result.
  typedef enum logic [3:0] {
    KIND_NONE       = 4'd0,
    KIND_FW_BYTE    = 4'd1,
    KIND_NAME_BYTE  = 4'd2,
    KIND_FILE_BYTE  = 4'd3,
    KIND_FW_BEGIN   = 4'd4,
    KIND_FW_END     = 4'd5,
    KIND_FILE_BEGIN = 4'd6,
    KIND_FILE_END   = 4'd7,
    KIND_FILE_EMPTY = 4'd8,
    KIND_DONE       = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    STAT_RUNNING = 2'd0,
    STAT_OK      = 2'd1,
    STAT_FAILED  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_FW_SIZE       = 3'd1,
    ERR_NAME_LONG     = 3'd2,
    ERR_PKG_LARGE     = 3'd3,
    ERR_FW_INCOMPLETE = 3'd4,
    ERR_FILE_TAIL     = 3'd5,
    ERR_META_TRUNC    = 3'd6
  } err_e;

  // Register addresses, by word index.
  localparam logic REG_FW_LIMIT  = 1'b0;
  localparam logic REG_PKG_LIMIT = 1'b1;

  localparam logic [31:0] FW_LIMIT_RESET  = 32'd1048576;
  localparam logic [31:0] PKG_LIMIT_RESET = 32'd2097152;

  localparam logic [7:0] SLASH = 8'h2F;

  // One result transaction as held in the output queue.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [31:0] len;
    stat_e       status;
    err_e        err;
    logic        last;
  } res_t;

  function automatic res_t mk_res(kind_e k, logic [7:0] d, logic [31:0] l);
    res_t r;
    r.kind   = k;
    r.data   = d;
    r.len    = l;
    r.status = STAT_RUNNING;
    r.err    = ERR_NONE;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/update_package_deframer.sv =====
// Channel   Direction  Handshake             Payload
// input     in         in_valid_i/in_stall_o mode_i, byte_value_i
// result    out        out_valid_o/out_stall_i kind_o, data_byte_o, length_value_o,
//                                            status_o, error_code_o, last_result_o
// config    in         APB write/read        paddr, pwdata, prdata
//
// Each byte is decoded in the cycle it is accepted; its one or two results enter a
// four-entry result queue and leave at one per cycle while out_stall_i is low, so
// single-result bytes flow at one per cycle; two-result bytes are slowed by the queue's
// single read port. The input is stalled while fewer than two queue entries are free.
// Reset returns the deframer to idle with both limits at their defaults; no clearing
// pass is needed.
module update_package_deframer
  import upd_pkg::*;
#(
  parameter int NAME_BUFFER_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  byte_value_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] length_value_o,
  output logic [1:0]  status_o,
  output logic [2:0]  error_code_o,
  output logic        last_result_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = $clog2(NAME_BUFFER_BYTES);

  // Configuration registers.
  logic [31:0] fw_limit_q, pkg_limit_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PKG_LIMIT) ? pkg_limit_q : fw_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_limit_q  <= FW_LIMIT_RESET;
      pkg_limit_q <= PKG_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PKG_LIMIT) begin
        pkg_limit_q <= pwdata;
      end else begin
        fw_limit_q <= pwdata;
      end
    end
  end

  // Deframer state.
  phase_e          phase_q, phase_d;
  err_e            err_q, err_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     left_q, left_d;
  logic [NW-1:0]   name_len_q, name_len_d;
  logic [NW-1:0]   name_cnt_q, name_cnt_d;
  logic [31:0]     total_q, total_d;

  // Result queue.
  res_t        fifo_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;

  logic        in_acc, pop;
  res_t        r0, r1;
  logic        two;
  logic [31:0] acc_new;
  logic [31:0] left_dec;
  logic [NW-1:0] name_cnt_inc;
  logic [15:0] len16;

  assign in_stall_o = (count_q > 3'd2);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 3'd0);
  assign pop        = out_valid_o && !out_stall_i;

  assign acc_new      = acc_q | (32'(byte_value_i) << {cnt_q, 3'b000});
  assign left_dec     = left_q - 32'd1;
  assign name_cnt_inc = name_cnt_q + NW'(1);
  assign len16        = acc_new[15:0];

  // Per-byte decode: next state and the results this transaction causes.
  always_comb begin
    phase_d    = phase_q;
    err_d      = err_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    left_d     = left_q;
    name_len_d = name_len_q;
    name_cnt_d = name_cnt_q;
    total_d    = total_q;
    r0         = mk_res(KIND_NONE, 8'd0, 32'd0);
    r1         = mk_res(KIND_NONE, 8'd0, 32'd0);
    two        = 1'b0;

    if (mode_i) begin
      // End of stream.
      case (phase_q)
        PH_DONE, PH_FAILED: begin
        end
        PH_NAMELEN: begin
          if (cnt_q == 2'd0) begin
            phase_d = PH_DONE;
            r0      = mk_res(KIND_DONE, 8'd0, 32'd0);
          end else begin
            phase_d = PH_FAILED;
            err_d   = ERR_META_TRUNC;
          end
        end
        PH_NAME, PH_FILESIZE, PH_FILEDATA: begin
          phase_d = PH_FAILED;
          err_d   = ERR_FILE_TAIL;
        end
        default: begin
          phase_d = PH_FAILED;
          err_d   = ERR_FW_INCOMPLETE;
        end
      endcase
    end else if (phase_q != PH_DONE && phase_q != PH_FAILED) begin
      if (total_q >= pkg_limit_q) begin
        // Package size limit reached: the byte is dropped.
        phase_d = PH_FAILED;
        err_d   = ERR_PKG_LARGE;
      end else begin
        total_d = total_q + 32'd1;
        case (phase_q)
          PH_IDLE, PH_HEADER: begin
            phase_d = PH_HEADER;
            cnt_d   = cnt_q + 2'd1;
            acc_d   = acc_new;
            if (cnt_q == 2'd3) begin
              if (acc_new == 32'd0 || acc_new > fw_limit_q) begin
                phase_d = PH_FAILED;
                err_d   = ERR_FW_SIZE;
              end else begin
                left_d  = acc_new;
                phase_d = PH_FIRMWARE;
                r0      = mk_res(KIND_FW_BEGIN, 8'd0, acc_new);
              end
            end
          end
          PH_FIRMWARE: begin
            r0     = mk_res(KIND_FW_BYTE, byte_value_i, 32'd0);
            left_d = left_dec;
            if (left_dec == 32'd0) begin
              phase_d = PH_NAMELEN;
              cnt_d   = 2'd0;
              acc_d   = 32'd0;
              r1      = mk_res(KIND_FW_END, 8'd0, 32'd0);
              two     = 1'b1;
            end
          end
          PH_NAMELEN: begin
            cnt_d = cnt_q + 2'd1;
            acc_d = acc_new;
            if (cnt_q == 2'd1) begin
              if (len16 == 16'd0) begin
                phase_d = PH_DONE;
                r0      = mk_res(KIND_DONE, 8'd0, 32'd0);
              end else if (len16 >= 16'(NAME_BUFFER_BYTES)) begin
                phase_d = PH_FAILED;
                err_d   = ERR_NAME_LONG;
              end else begin
                name_len_d = len16[NW-1:0];
                name_cnt_d = '0;
                phase_d    = PH_NAME;
              end
            end
          end
          PH_NAME: begin
            if (name_cnt_q == '0 && byte_value_i != SLASH &&
                name_len_q == NW'(NAME_BUFFER_BYTES - 1)) begin
              // No room left for the inserted slash.
              phase_d = PH_FAILED;
              err_d   = ERR_NAME_LONG;
            end else begin
              if (name_cnt_q == '0 && byte_value_i != SLASH) begin
                r0  = mk_res(KIND_NAME_BYTE, SLASH, 32'd0);
                r1  = mk_res(KIND_NAME_BYTE, byte_value_i, 32'd0);
                two = 1'b1;
              end else begin
                r0 = mk_res(KIND_NAME_BYTE, byte_value_i, 32'd0);
              end
              name_cnt_d = name_cnt_inc;
              if (name_cnt_inc == name_len_q) begin
                phase_d = PH_FILESIZE;
                cnt_d   = 2'd0;
                acc_d   = 32'd0;
              end
            end
          end
          PH_FILESIZE: begin
            cnt_d = cnt_q + 2'd1;
            acc_d = acc_new;
            if (cnt_q == 2'd3) begin
              if (acc_new == 32'd0) begin
                phase_d = PH_NAMELEN;
                cnt_d   = 2'd0;
                acc_d   = 32'd0;
                r0      = mk_res(KIND_FILE_EMPTY, 8'd0, 32'd0);
              end else begin
                left_d  = acc_new;
                phase_d = PH_FILEDATA;
                r0      = mk_res(KIND_FILE_BEGIN, 8'd0, acc_new);
              end
            end
          end
          PH_FILEDATA: begin
            r0     = mk_res(KIND_FILE_BYTE, byte_value_i, 32'd0);
            left_d = left_dec;
            if (left_dec == 32'd0) begin
              phase_d = PH_NAMELEN;
              cnt_d   = 2'd0;
              acc_d   = 32'd0;
              r1      = mk_res(KIND_FILE_END, 8'd0, 32'd0);
              two     = 1'b1;
            end
          end
          default: begin
            phase_d = PH_FAILED;
            err_d   = ERR_FW_INCOMPLETE;
          end
        endcase
      end
    end

    // Status and error code reflect the state after this transaction.
    if (phase_d == PH_DONE) begin
      r0.status = STAT_OK;
    end else if (phase_d == PH_FAILED) begin
      r0.status = STAT_FAILED;
    end
    r0.err    = err_d;
    r1.status = r0.status;
    r1.err    = err_d;
    r0.last   = !two;
    r1.last   = 1'b1;
  end

  // Deframer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      err_q      <= ERR_NONE;
      cnt_q      <= 2'd0;
      acc_q      <= 32'd0;
      left_q     <= 32'd0;
      name_len_q <= '0;
      name_cnt_q <= '0;
      total_q    <= 32'd0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      err_q      <= err_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      left_q     <= left_d;
      name_len_q <= name_len_d;
      name_cnt_q <= name_cnt_d;
      total_q    <= total_d;
    end
  end

  // Result queue payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fifo_q[wr_ptr_q] <= r0;
      if (two) begin
        fifo_q[wr_ptr_q + 2'd1] <= r1;
      end
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + (two ? 2'd2 : 2'd1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + (in_acc ? (two ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  // Head of the queue drives the result channel.
  assign kind_o         = fifo_q[rd_ptr_q].kind;
  assign data_byte_o    = fifo_q[rd_ptr_q].data;
  assign length_value_o = fifo_q[rd_ptr_q].len;
  assign status_o       = fifo_q[rd_ptr_q].status;
  assign error_code_o   = fifo_q[rd_ptr_q].err;
  assign last_result_o  = fifo_q[rd_ptr_q].last;

endmodule

// ===== rtl/core/upd_checker.sv =====
module upd_checker
  import upd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  kind_o,
  input logic [7:0]  data_byte_o,
  input logic [31:0] length_value_o,
  input logic [1:0]  status_o,
  input logic [2:0]  error_code_o
);

  // A stalled result transaction keeps its kind, data, length and status.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(data_byte_o) && $stable(length_value_o) && $stable(status_o))
    else $error("stalled result changed");

  // An error code is shown exactly when the status is failed.
  a_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == STAT_FAILED) == (error_code_o != ERR_NONE)))
    else $error("error code disagrees with status");

  // Only routed byte kinds carry data, only begin events carry a length.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_FW_BYTE && kind_o != KIND_NAME_BYTE &&
      kind_o != KIND_FILE_BYTE && kind_o != KIND_FW_BEGIN &&
      kind_o != KIND_FILE_BEGIN |-> data_byte_o == 8'd0 && length_value_o == 32'd0)
    else $error("unexpected payload on event result");

  // Once a failure is delivered, the next result still reports it.
  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && status_o == STAT_FAILED ##1 out_valid_o
      |-> status_o == STAT_FAILED && error_code_o == $past(error_code_o))
    else $error("failed status not held");

endmodule

bind update_package_deframer upd_checker u_upd_checker (.*);

// ===== bench/update_package_deframer_tb.sv =====
`timescale 1ns / 100ps

module update_package_deframer_tb
  import upd_pkg::*;
();

  localparam int NAME_BUF      = 64;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 16;

  // Ways in which the package stream is brought to its end.
  typedef enum int {
    FIN_ZERO_NAME_LEN,
    FIN_EOS_BOUNDARY,
    FIN_EOS_NAME_LEN,
    FIN_EOS_NAME,
    FIN_EOS_FILE_SIZE,
    FIN_EOS_FILE_DATA,
    FIN_NAME_TOO_LONG,
    FIN_SLASH_OVERFLOW,
    FIN_PKG_TOO_LARGE,
    FIN_EOS_AT_START,
    FIN_EOS_IN_HEADER,
    FIN_FW_SIZE_ZERO,
    FIN_FW_SIZE_OVER,
    FIN_EOS_IN_FIRMWARE
  } finale_e;

  // One line of the opening byte script, with the last event it should raise.
  typedef struct packed {
    logic        eos;
    logic [7:0]  b;
    logic        chk;
    kind_e       kind;
    logic [7:0]  d;
    logic [31:0] l;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [7:0]  byte_value_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [31:0] length_value_o;
  logic [1:0]  status_o;
  logic [2:0]  error_code_o;
  logic        last_result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Expectation for the directed byte in flight, travelling with its payload.
  logic        row_chk;
  kind_e       row_kind;
  logic [7:0]  row_data;
  logic [31:0] row_len;

  // Predicted deframer state and configuration.
  phase_e      pk_phase;
  logic [2:0]  pk_fcnt;
  logic [31:0] pk_facc;
  logic [31:0] pk_fw_left;
  logic [31:0] pk_file_left;
  logic [31:0] pk_taken;
  logic [15:0] pk_name_len;
  logic [15:0] pk_name_cnt;
  err_e        pk_err;
  logic [31:0] fw_size_limit;
  logic [31:0] pkg_size_limit;

  res_t        step_events[$];
  res_t        pending_events[$];

  int          gap_pct;
  int          stall_pct;
  int          fail_count;
  int          bytes_sent;
  int          results_seen;
  int          record_count;
  int          ignored_count;
  finale_e     finale;

  int          gap_by_phase[4]   = '{0, 50, 0, 7};
  int          stall_by_phase[4] = '{0, 0, 50, 7};

  // Opening of a package: header, three firmware bytes and two short records.
  script_row_t script [23] = '{
    '{1'b0, 8'h03, 1'b1, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b1, KIND_FW_BEGIN,   8'h00, 32'd3},
    '{1'b0, 8'hFF, 1'b1, KIND_FW_BYTE,    8'hFF, 32'd0},
    '{1'b0, 8'h00, 1'b1, KIND_FW_BYTE,    8'h00, 32'd0},
    '{1'b0, 8'hA5, 1'b1, KIND_FW_END,     8'h00, 32'd0},
    '{1'b0, 8'h02, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h61, 1'b1, KIND_NAME_BYTE,  8'h61, 32'd0},
    '{1'b0, 8'h62, 1'b1, KIND_NAME_BYTE,  8'h62, 32'd0},
    '{1'b0, 8'h01, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b1, KIND_FILE_BEGIN, 8'h00, 32'd1},
    '{1'b0, 8'h80, 1'b1, KIND_FILE_END,   8'h00, 32'd0},
    '{1'b0, 8'h01, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h2F, 1'b1, KIND_NAME_BYTE,  8'h2F, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b0, KIND_NONE,       8'h00, 32'd0},
    '{1'b0, 8'h00, 1'b1, KIND_FILE_EMPTY, 8'h00, 32'd0}
  };

  update_package_deframer #(
    .NAME_BUFFER_BYTES(NAME_BUF)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .byte_value_i   (byte_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .length_value_o (length_value_o),
    .status_o       (status_o),
    .error_code_o   (error_code_o),
    .last_result_o  (last_result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void flag_mismatch(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Records one predicted event, stamped with the status as it now stands.
  function automatic void note_event(kind_e k, logic [7:0] d, logic [31:0] l);
    res_t r;
    r.kind   = k;
    r.data   = d;
    r.len    = l;
    r.status = (pk_phase == PH_DONE) ? STAT_OK :
               (pk_phase == PH_FAILED) ? STAT_FAILED : STAT_RUNNING;
    r.err    = pk_err;
    r.last   = 1'b0;
    step_events.push_back(r);
  endfunction

  function automatic void enter_field(phase_e nxt);
    pk_phase = nxt;
    pk_fcnt  = '0;
    pk_facc  = '0;
  endfunction

  function automatic void abort_package(err_e code);
    pk_phase = PH_FAILED;
    pk_err   = code;
  endfunction

  // Shifts a byte into the little-endian field; true once it holds `need` bytes.
  function automatic bit field_full(logic [7:0] b, int unsigned need);
    pk_facc = pk_facc | (32'(b) << (8 * pk_fcnt[1:0]));
    pk_fcnt = pk_fcnt + 3'd1;
    return pk_fcnt >= need;
  endfunction

  // Routes one package byte through the predicted deframer.
  function automatic void deframe_byte(logic [7:0] b);
    if (pk_phase == PH_DONE || pk_phase == PH_FAILED) begin
      note_event(KIND_NONE, 8'h00, 32'd0);
      return;
    end
    if (pk_phase == PH_IDLE) enter_field(PH_HEADER);
    // The byte is dropped when it would take the package past its limit.
    if ({1'b0, pk_taken} + 33'd1 > {1'b0, pkg_size_limit}) begin
      abort_package(ERR_PKG_LARGE);
      note_event(KIND_NONE, 8'h00, 32'd0);
      return;
    end
    pk_taken = pk_taken + 32'd1;
    case (pk_phase)
      PH_HEADER: begin
        if (!field_full(b, 4)) begin
          note_event(KIND_NONE, 8'h00, 32'd0);
        end else if (pk_facc == 32'd0 || pk_facc > fw_size_limit) begin
          abort_package(ERR_FW_SIZE);
          note_event(KIND_NONE, 8'h00, 32'd0);
        end else begin
          pk_fw_left = pk_facc;
          pk_phase   = PH_FIRMWARE;
          note_event(KIND_FW_BEGIN, 8'h00, pk_fw_left);
        end
      end
      PH_FIRMWARE: begin
        note_event(KIND_FW_BYTE, b, 32'd0);
        pk_fw_left = pk_fw_left - 32'd1;
        if (pk_fw_left == 32'd0) begin
          enter_field(PH_NAMELEN);
          note_event(KIND_FW_END, 8'h00, 32'd0);
        end
      end
      PH_NAMELEN: begin
        if (!field_full(b, 2)) begin
          note_event(KIND_NONE, 8'h00, 32'd0);
        end else begin
          pk_name_len = pk_facc[15:0];
          if (pk_name_len == 16'd0) begin
            pk_phase = PH_DONE;
            note_event(KIND_DONE, 8'h00, 32'd0);
          end else if (32'(pk_name_len) >= NAME_BUF) begin
            abort_package(ERR_NAME_LONG);
            note_event(KIND_NONE, 8'h00, 32'd0);
          end else begin
            pk_name_cnt = 16'd0;
            pk_phase    = PH_NAME;
            note_event(KIND_NONE, 8'h00, 32'd0);
          end
        end
      end
      PH_NAME: begin
        // A name without a leading slash gets one, if the buffer has room.
        if (pk_name_cnt == 16'd0 && b != SLASH && 32'(pk_name_len) + 1 >= NAME_BUF) begin
          abort_package(ERR_NAME_LONG);
          note_event(KIND_NONE, 8'h00, 32'd0);
        end else begin
          if (pk_name_cnt == 16'd0 && b != SLASH) begin
            note_event(KIND_NAME_BYTE, SLASH, 32'd0);
          end
          note_event(KIND_NAME_BYTE, b, 32'd0);
          pk_name_cnt = pk_name_cnt + 16'd1;
          if (pk_name_cnt >= pk_name_len) enter_field(PH_FILESIZE);
        end
      end
      PH_FILESIZE: begin
        if (!field_full(b, 4)) begin
          note_event(KIND_NONE, 8'h00, 32'd0);
        end else if (pk_facc == 32'd0) begin
          enter_field(PH_NAMELEN);
          note_event(KIND_FILE_EMPTY, 8'h00, 32'd0);
        end else begin
          pk_file_left = pk_facc;
          pk_phase     = PH_FILEDATA;
          note_event(KIND_FILE_BEGIN, 8'h00, pk_file_left);
        end
      end
      PH_FILEDATA: begin
        note_event(KIND_FILE_BYTE, b, 32'd0);
        pk_file_left = pk_file_left - 32'd1;
        if (pk_file_left == 32'd0) begin
          enter_field(PH_NAMELEN);
          note_event(KIND_FILE_END, 8'h00, 32'd0);
        end
      end
      default: begin
        abort_package(ERR_FW_INCOMPLETE);
        note_event(KIND_NONE, 8'h00, 32'd0);
      end
    endcase
  endfunction

  // End of stream: clean only at a record boundary.
  function automatic void deframe_end();
    case (pk_phase)
      PH_DONE, PH_FAILED: begin
        note_event(KIND_NONE, 8'h00, 32'd0);
      end
      PH_NAMELEN: begin
        if (pk_fcnt == 3'd0) begin
          pk_phase = PH_DONE;
          note_event(KIND_DONE, 8'h00, 32'd0);
        end else begin
          abort_package(ERR_META_TRUNC);
          note_event(KIND_NONE, 8'h00, 32'd0);
        end
      end
      PH_NAME, PH_FILESIZE, PH_FILEDATA: begin
        abort_package(ERR_FILE_TAIL);
        note_event(KIND_NONE, 8'h00, 32'd0);
      end
      default: begin
        abort_package(ERR_FW_INCOMPLETE);
        note_event(KIND_NONE, 8'h00, 32'd0);
      end
    endcase
  endfunction

  // Expected events of one accepted input transaction, appended in order.
  function automatic void predict_transaction(logic eos, logic [7:0] b);
    step_events.delete();
    if (eos) begin
      deframe_end();
    end else begin
      deframe_byte(b);
    end
    step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) pending_events.push_back(step_events[i]);
  endfunction

  // Prediction on input transactions, then comparison of result transactions.
  always @(posedge clk_i) begin : scoreboard_p
    res_t want;
    res_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_transaction(mode_i, byte_value_i);
        if (row_chk) begin
          want = step_events[step_events.size() - 1];
          if (want.kind != row_kind || want.data != row_data || want.len != row_len ||
              want.status != STAT_RUNNING || want.err != ERR_NONE) begin
            flag_mismatch($sformatf("mismatch: script byte %h predicts kind %0d data %h len %h",
                                    byte_value_i, want.kind, want.data, want.len));
          end
        end
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        got.kind   = kind_e'(kind_o);
        got.data   = data_byte_o;
        got.len    = length_value_o;
        got.status = stat_e'(status_o);
        got.err    = err_e'(error_code_o);
        got.last   = last_result_o;
        if (pending_events.size() == 0) begin
          flag_mismatch($sformatf("mismatch: unexpected result kind %0d data %h len %h",
                                  got.kind, got.data, got.len));
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            flag_mismatch($sformatf({"mismatch at result %0d: expected kind %0d data %h ",
                                     "len %h status %0d err %0d last %b, got kind %0d data %h ",
                                     "len %h status %0d err %0d last %b"},
                                    results_seen, want.kind, want.data, want.len, want.status,
                                    want.err, want.last, got.kind, got.data, got.len,
                                    got.status, got.err, got.last));
          end
        end
      end
    end
  end

  // Offers one input transaction, after a random gap, and waits for its acceptance.
  task automatic send_item(input logic eos, input logic [7:0] b, input logic chk = 1'b0,
                           input kind_e k = KIND_NONE, input logic [7:0] d = 8'h00,
                           input logic [31:0] l = 32'd0);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= eos;
    byte_value_i <= b;
    row_chk      <= chk;
    row_kind     <= k;
    row_data     <= d;
    row_len      <= l;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) begin
      send_item(1'b0, v[8 * i +: 8]);
    end
  endtask

  // One well-formed file record with random name and contents.
  task automatic send_record();
    int unsigned nlen;
    int unsigned fsize;
    logic [7:0]  b;
    nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(32, NAME_BUF - 1) : $urandom_range(1, 8);
    send_word(nlen, 2);
    for (int i = 0; i < nlen; i++) begin
      b = rand_byte();
      // A name that fills the buffer must bring its own slash.
      if (i == 0 && (nlen == NAME_BUF - 1 || $urandom_range(0, 2) == 0)) b = SLASH;
      send_item(1'b0, b);
    end
    case ($urandom_range(0, 9))
      0: fsize = 0;
      1: fsize = $urandom_range(64, 200);
      default: fsize = $urandom_range(1, 12);
    endcase
    send_word(fsize, 4);
    repeat (fsize) send_item(1'b0, rand_byte());
    record_count++;
  endtask

  // Waits until every predicted result has arrived and the block has gone quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write followed by a read-back of the same register.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_FW_LIMIT) begin
      fw_size_limit = val;
    end else begin
      pkg_size_limit = val;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      flag_mismatch($sformatf("mismatch: register %0d reads %h, written %h", idx, prdata, val));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus_p
    int unsigned lim;
    int unsigned n;
    int          target;
    logic [7:0]  b;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= 1'b0;
    byte_value_i <= 8'h00;
    row_chk      <= 1'b0;
    row_kind     <= KIND_NONE;
    row_data     <= 8'h00;
    row_len      <= 32'd0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    gap_pct        = 0;
    stall_pct      = 0;
    pk_phase       = PH_IDLE;
    pk_fcnt        = '0;
    pk_facc        = '0;
    pk_fw_left     = '0;
    pk_file_left   = '0;
    pk_taken       = '0;
    pk_name_len    = '0;
    pk_name_cnt    = '0;
    pk_err         = ERR_NONE;
    fw_size_limit  = FW_LIMIT_RESET;
    pkg_size_limit = PKG_LIMIT_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Most runs carry a full package; some end it before or during the firmware stage.
    if ($urandom_range(0, 7) == 0) begin
      finale = finale_e'($urandom_range(FIN_EOS_AT_START, FIN_EOS_IN_FIRMWARE));
    end else begin
      finale = finale_e'($urandom_range(FIN_ZERO_NAME_LEN, FIN_PKG_TOO_LARGE));
    end

    if (finale >= FIN_EOS_AT_START) begin
      gap_pct   = 7;
      stall_pct = 7;
      write_reg(REG_PKG_LIMIT, 32'hFFFF_FFFF);
      case (finale)
        FIN_EOS_AT_START: begin
          send_item(1'b1, rand_byte());
        end
        FIN_EOS_IN_HEADER: begin
          send_word($urandom, $urandom_range(1, 3));
          send_item(1'b1, rand_byte());
        end
        FIN_FW_SIZE_ZERO: begin
          send_word(32'd0, 4);
        end
        FIN_FW_SIZE_OVER: begin
          lim = $urandom_range(1, 1000);
          write_reg(REG_FW_LIMIT, lim);
          send_word(lim + 1, 4);
        end
        default: begin
          write_reg(REG_FW_LIMIT, 32'hFFFF_FFFF);
          n = $urandom_range(300, 1600);
          send_word(n, 4);
          repeat (n - $urandom_range(1, 20)) send_item(1'b0, rand_byte());
          send_item(1'b1, rand_byte());
        end
      endcase
    end else begin
      // The firmware limit equals the scripted firmware size.
      write_reg(REG_FW_LIMIT, 32'd3);
      write_reg(REG_PKG_LIMIT, 32'hFFFF_FFFF);
      foreach (script[i]) begin
        send_item(script[i].eos, script[i].b, script[i].chk, script[i].kind,
                  script[i].d, script[i].l);
      end

      // Random records in four stretches of idling, limits changed in between.
      for (int ph = 0; ph < 4; ph++) begin
        gap_pct   = gap_by_phase[ph];
        stall_pct = stall_by_phase[ph];
        target    = bytes_sent + RANDOM_ITEMS / 4;
        while (bytes_sent < target) send_record();
        drain();
        case (ph)
          0: begin
            write_reg(REG_FW_LIMIT, 32'd1);
            write_reg(REG_PKG_LIMIT, pk_taken + $urandom_range(5000, 100000));
          end
          1: write_reg(REG_FW_LIMIT, 32'hFFFF_FFFF);
          2: write_reg(REG_PKG_LIMIT, 32'hFFFF_FFFF);
          default: ;
        endcase
      end

      case (finale)
        FIN_ZERO_NAME_LEN: begin
          send_word(32'd0, 2);
        end
        FIN_EOS_BOUNDARY: begin
          send_item(1'b1, rand_byte());
        end
        FIN_EOS_NAME_LEN: begin
          send_item(1'b0, rand_byte());
          send_item(1'b1, rand_byte());
        end
        FIN_EOS_NAME: begin
          send_word($urandom_range(2, 40), 2);
          send_item(1'b0, rand_byte());
          send_item(1'b1, rand_byte());
        end
        FIN_EOS_FILE_SIZE: begin
          send_word(32'd1, 2);
          send_item(1'b0, rand_byte());
          send_word($urandom, $urandom_range(1, 3));
          send_item(1'b1, rand_byte());
        end
        FIN_EOS_FILE_DATA: begin
          n = $urandom_range(2, 50);
          send_word(32'd1, 2);
          send_item(1'b0, rand_byte());
          send_word(n, 4);
          repeat ($urandom_range(1, n - 1)) send_item(1'b0, rand_byte());
          send_item(1'b1, rand_byte());
        end
        FIN_NAME_TOO_LONG: begin
          send_word($urandom_range(NAME_BUF, 65535), 2);
        end
        FIN_SLASH_OVERFLOW: begin
          send_word(NAME_BUF - 1, 2);
          b = rand_byte();
          if (b == SLASH) b = 8'h30;
          send_item(1'b0, b);
        end
        default: begin
          // The limit is met exactly, so the very next byte is refused.
          write_reg(REG_PKG_LIMIT, pk_taken);
          send_item(1'b0, rand_byte());
        end
      endcase
    end

    // Once the package has ended, further bytes and end markers change nothing.
    // Short runs are topped up here to the full number of input transactions.
    drain();
    write_reg(REG_PKG_LIMIT, 32'd1);
    n = $urandom_range(2, 5);
    while (ignored_count < n || bytes_sent < RANDOM_ITEMS) begin
      send_item(1'b0, rand_byte());
      ignored_count++;
    end
    send_item(1'b1, rand_byte());
    send_item(1'b0, rand_byte());
    ignored_count += 2;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input and %0d result transactions over %0d file records.",
             bytes_sent, results_seen, record_count);
    $display("Package closed by %s, then %0d trailing transactions were ignored.",
             finale.name(), ignored_count);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #4_000_000;
    $display("Run timed out with %0d results still awaited.", pending_events.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== update_package_deframer.f =====
rtl/core/upd_pkg.sv
rtl/core/update_package_deframer.sv
rtl/core/upd_checker.sv
bench/update_package_deframer_tb.sv
